[rtl/launch_detect_window_stats_unit_macros.svh]
// assertion macros for the launch detector checker
`ifndef LAUNCH_DETECT_WINDOW_STATS_UNIT_MACROS_SVH
`define LAUNCH_DETECT_WINDOW_STATS_UNIT_MACROS_SVH

// checked outside reset
`define LDS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("launch detector assertion failed");

// checked on every rising edge, also during reset
`define LDS_ASSERT_NR(label, prop) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error("launch detector assertion failed");

`endif

[rtl/lds_pkg.sv]
// shared types and constants of the launch detector
`default_nettype none
package lds_pkg;
    localparam int RING_DEPTH_DEF = 1024;
    localparam int WINDOW_DEF     = 300;
    localparam int LAG_DEF        = 300;
    localparam int MAG_W          = 16;
    localparam int THR_W          = 16;
    localparam int K_W            = 4;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_ADDR_W     = 1;
    localparam int Q_DEPTH        = 2;
    localparam int IN_DATA_W      = 48;
    localparam int OUT_DATA_W     = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_REJECT    = 1'd1;

    localparam logic [THR_W-1:0] THR_RST = 16'd12544;
    localparam logic [K_W-1:0]   K_RST   = 4'd3;

    typedef struct packed {
        logic [THR_W-1:0] thr;
        logic [K_W-1:0]   k;
    } t_cfg;
endpackage
`default_nettype wire

[rtl/launch_detect_window_stats_unit.sv]
// Launch detector top level. One transfer on the sample stream carries a three-axis
// acceleration; one transfer on the result stream follows for each, with the latched
// launch flag and the outlier-filtered window mean. The front end takes one sample
// at a time (squares and a 16-step square root); the back end sets the rate, bounded
// by two passes over the window through the single read port of the ring memory and
// a serial divide with a 16 + clog2(WINDOW+1) bit quotient; the divide is skipped when
// no window sample is kept. After reset the ring memory is cleared one entry a cycle,
// during which s_axis_tready stays low. Once launch is seen, samples are no longer
// stored in the ring memory and the back end returns a zero mean for each.
`default_nettype none
module launch_detect_window_stats_unit #(
    parameter int RING_DEPTH = lds_pkg::RING_DEPTH_DEF,
    parameter int WINDOW     = lds_pkg::WINDOW_DEF,
    parameter int LAG        = lds_pkg::LAG_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire [lds_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // accel_x, accel_y, accel_z
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [lds_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // filtered_mean
    output logic [0:0]                         m_axis_tuser,  // launch_seen
    input  wire                                i_cfg_we,
    input  wire [lds_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire [lds_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    lds_pkg::t_cfg r_cfg;
    logic en, fq_valid, fq_ready, bq_valid, bq_ready, seen;
    logic [lds_pkg::MAG_W-1:0] fq_data, bq_data, mean;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr <= lds_pkg::THR_RST;
            r_cfg.k   <= lds_pkg::K_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lds_pkg::CFG_THRESHOLD: r_cfg.thr <= i_cfg_wdata;
                lds_pkg::CFG_REJECT:    r_cfg.k   <= i_cfg_wdata[lds_pkg::K_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lds_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_accel_x (s_axis_tdata[15:0]),
        .i_accel_y (s_axis_tdata[31:16]),
        .i_accel_z (s_axis_tdata[47:32]),
        .o_q_valid (fq_valid),
        .i_q_ready (fq_ready),
        .o_q_data  (fq_data)
    );

    lds_fifo #(.DEPTH(lds_pkg::Q_DEPTH)) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_data  (fq_data),
        .o_pop_valid  (bq_valid),
        .i_pop_ready  (bq_ready),
        .o_pop_data   (bq_data)
    );

    lds_back #(.RING_DEPTH(RING_DEPTH), .WINDOW(WINDOW), .LAG(LAG)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (bq_valid),
        .o_q_ready  (bq_ready),
        .i_q_data   (bq_data),
        .o_ready_in (en),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_m_mean   (mean),
        .o_m_seen   (seen)
    );

    assign m_axis_tdata = mean;
    assign m_axis_tuser = seen;
endmodule
`default_nettype wire

[rtl/lds_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module lds_ram #(
    parameter int WIDTH = lds_pkg::MAG_W,
    parameter int DEPTH = lds_pkg::RING_DEPTH_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/lds_fifo.sv]
// short magnitude queue between front and back
`default_nettype none
module lds_fifo #(
    parameter int DEPTH = lds_pkg::Q_DEPTH
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_push_valid,
    output logic                     o_push_ready,
    input  wire [lds_pkg::MAG_W-1:0] i_push_data,
    output logic                     o_pop_valid,
    input  wire                      i_pop_ready,
    output logic [lds_pkg::MAG_W-1:0] o_pop_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [lds_pkg::MAG_W-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;
    logic push, pop;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/lds_front.sv]
// front end: sample capture, squares and iterative square root
`default_nettype none
module lds_front (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_en,
    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire signed [15:0]         i_accel_x,
    input  wire signed [15:0]         i_accel_y,
    input  wire signed [15:0]         i_accel_z,
    output logic                      o_q_valid,
    input  wire                       i_q_ready,
    output logic [lds_pkg::MAG_W-1:0] o_q_data
);
    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_SQ   = 5'b00010,
        F_SUM  = 5'b00100,
        F_ROOT = 5'b01000,
        F_PUSH = 5'b10000
    } t_fstate;

    t_fstate r_state;
    logic signed [15:0] r_x, r_y, r_z;
    logic [31:0] r_sqx, r_sqy, r_sqz;
    logic [31:0] r_rad, r_root, r_bit;
    logic signed [31:0] px, py, pz;
    logic [32:0] trial;

    assign o_ready   = (r_state == F_IDLE) && i_en;
    assign o_q_valid = (r_state == F_PUSH);
    assign o_q_data  = r_root[lds_pkg::MAG_W-1:0];

    assign px    = r_x * r_x;
    assign py    = r_y * r_y;
    assign pz    = r_z * r_z;
    assign trial = {1'b0, r_root} + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                r_x <= i_accel_x;
                r_y <= i_accel_y;
                r_z <= i_accel_z;
            end
            F_SQ: begin
                r_sqx <= unsigned'(px);
                r_sqy <= unsigned'(py);
                r_sqz <= unsigned'(pz);
            end
            F_SUM: begin
                r_rad  <= r_sqx + r_sqy + r_sqz;
                r_root <= '0;
                r_bit  <= 32'h4000_0000;
            end
            F_ROOT: begin
                if ({1'b0, r_rad} >= trial) begin
                    r_rad  <= r_rad - trial[31:0];
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: if (i_valid && o_ready) r_state <= F_SQ;
                F_SQ:   r_state <= F_SUM;
                F_SUM:  r_state <= F_ROOT;
                F_ROOT: if (r_bit[0]) r_state <= F_PUSH;
                F_PUSH: if (i_q_ready) r_state <= F_IDLE;
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/lds_back.sv]
// back end: ring store, window statistics, outlier filter, divide and result register
`default_nettype none
module lds_back #(
    parameter int RING_DEPTH = lds_pkg::RING_DEPTH_DEF,
    parameter int WINDOW     = lds_pkg::WINDOW_DEF,
    parameter int LAG        = lds_pkg::LAG_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  lds_pkg::t_cfg             i_cfg,
    input  wire                       i_q_valid,
    output logic                      o_q_ready,
    input  wire [lds_pkg::MAG_W-1:0]  i_q_data,
    output logic                      o_ready_in,
    output logic                      o_m_valid,
    input  wire                       i_m_ready,
    output logic [lds_pkg::MAG_W-1:0] o_m_mean,
    output logic                      o_m_seen
);
    localparam int MW    = lds_pkg::MAG_W;
    localparam int AW    = $clog2(RING_DEPTH);
    localparam int WW    = $clog2(WINDOW + 1);
    localparam int S_W   = MW + WW;
    localparam int Q_W   = 2 * MW + WW;
    localparam int D_W   = Q_W + WW;
    localparam int C_W   = 2 * lds_pkg::K_W + WW;
    localparam int DC_W  = D_W + C_W;
    localparam int L_W   = 2 * S_W + WW;
    localparam int DVC_W = $clog2(S_W + 1);
    localparam int LAG_M = LAG % RING_DEPTH;

    typedef enum logic [9:0] {
        B_CLEAR = 10'b0000000001,
        B_IDLE  = 10'b0000000010,
        B_WRITE = 10'b0000000100,
        B_SUM   = 10'b0000001000,
        B_VAR1  = 10'b0000010000,
        B_VAR2  = 10'b0000100000,
        B_VAR3  = 10'b0001000000,
        B_KEEP  = 10'b0010000000,
        B_DIV   = 10'b0100000000,
        B_DONE  = 10'b1000000000
    } t_bstate;

    t_bstate r_state;
    logic [AW-1:0] r_wp, r_clr, r_raddr;
    logic [MW-1:0] r_mag;
    logic r_skip, r_launched;
    logic [WW-1:0] r_cnt;
    logic [4:0] r_pv;
    logic [S_W-1:0] r_s;
    logic [2*MW-1:0] r_sq;
    logic [Q_W-1:0] r_q;
    logic [2*S_W-1:0] r_ss;
    logic [D_W-1:0] r_wq, r_d;
    logic [C_W-1:0] r_c;
    logic [DC_W-1:0] r_dc;
    logic [S_W-1:0] r_wm, r_a;
    logic [2*S_W-1:0] r_a2;
    logic [L_W-1:0] r_lhs;
    logic [MW-1:0] r_m1, r_m2, r_m3, r_m4;
    logic [S_W-1:0] r_ksum;
    logic [WW-1:0] r_kcnt;
    logic [S_W-1:0] r_quo;
    logic [WW-1:0] r_rem;
    logic [DVC_W-1:0] r_dcnt;

    logic [MW-1:0] rdata;
    logic ram_we;
    logic [AW-1:0] ram_waddr;
    logic [MW-1:0] ram_wdata;
    logic issue, pass_done, out_free, good, out_load;
    logic [AW:0] start_sum;
    logic [AW-1:0] start_addr;
    logic [WW:0] dv_trial;

    lds_ram #(.WIDTH(MW), .DEPTH(RING_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_raddr),
        .o_rdata (rdata)
    );

    assign ram_we    = (r_state == B_CLEAR) || (r_state == B_WRITE);
    assign ram_waddr = (r_state == B_CLEAR) ? r_clr : r_wp;
    assign ram_wdata = (r_state == B_CLEAR) ? '0 : r_mag;

    assign start_sum  = {1'b0, r_wp} + (AW+1)'(RING_DEPTH - LAG_M);
    assign start_addr = (start_sum >= (AW+1)'(RING_DEPTH)) ?
                        AW'(start_sum - (AW+1)'(RING_DEPTH)) : start_sum[AW-1:0];

    assign issue     = ((r_state == B_SUM) || (r_state == B_KEEP)) && (r_cnt != WW'(WINDOW));
    assign pass_done = (r_cnt == WW'(WINDOW)) && (r_pv == '0);
    assign out_free  = !o_m_valid || i_m_ready;
    assign out_load  = (r_state == B_DONE) && out_free;
    assign good      = !r_skip && (r_kcnt != '0);
    assign dv_trial  = {r_rem, r_quo[S_W-1]};

    assign o_q_ready  = (r_state == B_IDLE);
    assign o_ready_in = (r_state != B_CLEAR);

    // datapath
    always_ff @(posedge i_clk) begin
        r_pv <= {r_pv[3:0], issue};
        if (issue) begin
            r_cnt   <= r_cnt + 1'b1;
            r_raddr <= (r_raddr == '0) ? AW'(RING_DEPTH - 1) : r_raddr - 1'b1;
        end
        case (r_state)
            B_IDLE: begin
                r_mag  <= i_q_data;
                r_skip <= r_launched;
            end
            B_WRITE: begin
                r_raddr <= start_addr;
                r_cnt   <= '0;
                r_s     <= '0;
                r_q     <= '0;
            end
            B_SUM: begin
                if (r_pv[0]) begin
                    r_s  <= r_s + S_W'(rdata);
                    r_sq <= rdata * rdata;
                end
                if (r_pv[1]) begin
                    r_q <= r_q + Q_W'(r_sq);
                end
            end
            B_VAR1: begin
                r_ss <= r_s * r_s;
                r_wq <= D_W'(WINDOW) * D_W'(r_q);
            end
            B_VAR2: begin
                r_d <= r_wq - D_W'(r_ss);
                r_c <= C_W'(i_cfg.k) * C_W'(i_cfg.k) * C_W'(WINDOW);
            end
            B_VAR3: begin
                r_dc    <= DC_W'(r_d) * DC_W'(r_c);
                r_raddr <= start_addr;
                r_cnt   <= '0;
                r_ksum  <= '0;
                r_kcnt  <= '0;
            end
            B_KEEP: begin
                if (r_pv[0]) begin
                    r_wm <= S_W'(WINDOW) * S_W'(rdata);
                    r_m1 <= rdata;
                end
                if (r_pv[1]) begin
                    r_a  <= (r_wm >= r_s) ? r_wm - r_s : r_s - r_wm;
                    r_m2 <= r_m1;
                end
                if (r_pv[2]) begin
                    r_a2 <= r_a * r_a;
                    r_m3 <= r_m2;
                end
                if (r_pv[3]) begin
                    r_lhs <= L_W'(r_a2) * L_W'(WINDOW - 1);
                    r_m4  <= r_m3;
                end
                if (r_pv[4] && (DC_W'(r_lhs) < r_dc)) begin
                    r_ksum <= r_ksum + S_W'(r_m4);
                    r_kcnt <= r_kcnt + 1'b1;
                end
                if (pass_done) begin
                    r_quo  <= r_ksum;
                    r_rem  <= '0;
                    r_dcnt <= '0;
                end
            end
            B_DIV: begin
                if (dv_trial >= {1'b0, r_kcnt}) begin
                    r_rem <= WW'(dv_trial - {1'b0, r_kcnt});
                    r_quo <= {r_quo[S_W-2:0], 1'b1};
                end else begin
                    r_rem <= dv_trial[WW-1:0];
                    r_quo <= {r_quo[S_W-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // control and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_CLEAR;
            r_clr      <= '0;
            r_wp       <= '0;
            r_launched <= 1'b0;
            o_m_valid  <= 1'b0;
        end else begin
            if (out_load) begin
                o_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                o_m_valid <= 1'b0;
            end
            case (r_state)
                B_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(RING_DEPTH - 1)) r_state <= B_IDLE;
                end
                B_IDLE: begin
                    if (i_q_valid) r_state <= r_launched ? B_DONE : B_WRITE;
                end
                B_WRITE: r_state <= B_SUM;
                B_SUM:   if (pass_done) r_state <= B_VAR1;
                B_VAR1:  r_state <= B_VAR2;
                B_VAR2:  r_state <= B_VAR3;
                B_VAR3:  r_state <= B_KEEP;
                B_KEEP: begin
                    if (pass_done) r_state <= (r_kcnt == '0) ? B_DONE : B_DIV;
                end
                B_DIV: begin
                    if (r_dcnt == DVC_W'(S_W - 1)) r_state <= B_DONE;
                end
                B_DONE: begin
                    if (out_free) begin
                        o_m_mean  <= good ? r_quo[MW-1:0] : '0;
                        o_m_seen  <= r_launched ||
                                     (good && (r_quo > S_W'(i_cfg.thr)));
                        if (good && (r_quo > S_W'(i_cfg.thr))) r_launched <= 1'b1;
                        if (!r_skip) begin
                            r_wp <= (r_wp == AW'(RING_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                        end
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/launch_detect_window_stats_unit_checker.sv]
// port-level checker for the launch detector, bound to the top level
`default_nettype none
`include "launch_detect_window_stats_unit_macros.svh"
module launch_detect_window_stats_unit_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata,
    input wire [0:0]  m_axis_tuser
);
    logic r_seen;
    logic [16:0] out_word;

    assign out_word = {m_axis_tuser, m_axis_tdata};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser[0]) begin
            r_seen <= 1'b1;
        end
    end

    `LDS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(out_word))
    `LDS_ASSERT(a_seen_sticky, r_seen && m_axis_tvalid |-> m_axis_tuser[0])
    `LDS_ASSERT(a_seen_zero_mean, r_seen && m_axis_tvalid |-> m_axis_tdata == 16'd0)
    `LDS_ASSERT(a_clear_after_reset, !$past(i_rst_n) |-> !s_axis_tready)
    `LDS_ASSERT_NR(a_reset_clears_seen, !i_rst_n |=> !r_seen)
endmodule

bind launch_detect_window_stats_unit launch_detect_window_stats_unit_checker u_chk (.*);
`default_nettype wire

[sim/launch_detect_window_stats_unit_tb.sv]
// self-checking testbench of the launch detector: random and directed samples against a predictor
`default_nettype none
module launch_detect_window_stats_unit_tb;
    localparam int WD_LIMIT  = 20000;
    localparam int HOLD_LEN  = 3000;
    localparam int WIN       = lds_pkg::WINDOW_DEF;
    localparam int LAGN      = lds_pkg::LAG_DEF;
    localparam int DEPTH     = lds_pkg::RING_DEPTH_DEF;

    typedef struct packed {
        logic                      launch_seen;
        logic [lds_pkg::MAG_W-1:0] filtered_mean;
    } t_launch_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [lds_pkg::IN_DATA_W-1:0]  s_axis_tdata;  // accel_x, accel_y, accel_z
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [lds_pkg::OUT_DATA_W-1:0] m_axis_tdata;  // filtered_mean
    logic [0:0]                     m_axis_tuser;  // launch_seen
    logic                           i_cfg_we;
    logic [lds_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [lds_pkg::CFG_DATA_W-1:0] i_cfg_wdata;

    launch_detect_window_stats_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // predictor state
    logic [lds_pkg::MAG_W-1:0] mag_ring [DEPTH];
    int                        wr_ptr;
    bit                        launched;
    logic [lds_pkg::THR_W-1:0] thr_reg;
    logic [lds_pkg::K_W-1:0]   k_reg;

    t_launch_result pending_results[$];
    int  n_sent;
    int  n_checked = 0;
    int  n_mismatch = 0;
    int  n_launch_seen = 0;
    int  hold_req;
    int  hold_ack = 0;
    int  hold_cycles = 0;
    int  rx_gap = 0;
    bit  no_idle;
    int  idle_cycles = 0;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic logic [lds_pkg::MAG_W-1:0] isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[lds_pkg::MAG_W-1:0];
    endfunction

    function automatic int window_idx(int i);
        return (wr_ptr + DEPTH - ((LAGN + i) % DEPTH)) % DEPTH;
    endfunction

    function automatic t_launch_result predict_sample(logic signed [15:0] ax,
                                                      logic signed [15:0] ay,
                                                      logic signed [15:0] az);
        longint          xs, ys, zs;
        longint unsigned s, q, d, c, m, wm, a, lhs, ksum, kcnt, mean;
        t_launch_result  res;
        xs = ax;
        ys = ay;
        zs = az;
        s = 0;
        q = 0;
        ksum = 0;
        kcnt = 0;
        mean = 0;
        if (launched) begin
            res.launch_seen = 1'b1;
            res.filtered_mean = '0;
            return res;
        end
        mag_ring[wr_ptr] = isqrt(longint'(xs * xs + ys * ys + zs * zs));
        for (int i = 0; i < WIN; i++) begin
            m = mag_ring[window_idx(i)];
            s += m;
            q += m * m;
        end
        d = longint'(WIN) * q - s * s;
        c = longint'(k_reg) * longint'(k_reg) * longint'(WIN);
        if (c != 0) begin
            for (int i = 0; i < WIN; i++) begin
                m = mag_ring[window_idx(i)];
                wm = longint'(WIN) * m;
                a = (wm >= s) ? wm - s : s - wm;
                lhs = a * a * longint'(WIN - 1);
                if (lhs / c < d) begin
                    ksum += m;
                    kcnt++;
                end
            end
        end
        if (kcnt != 0) begin
            mean = ksum / kcnt;
            if (mean > thr_reg) launched = 1'b1;
        end
        wr_ptr = (wr_ptr + 1) % DEPTH;
        res.launch_seen = launched;
        res.filtered_mean = mean[lds_pkg::MAG_W-1:0];
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(20, 150);
    endfunction

    task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {az, ay, ax};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.insert(pending_results.size(), predict_sample(ax, ay, az));
        n_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [lds_pkg::CFG_ADDR_W-1:0] addr,
                             logic [lds_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (addr == lds_pkg::CFG_THRESHOLD) thr_reg = val[lds_pkg::THR_W-1:0];
        else if (addr == lds_pkg::CFG_REJECT) k_reg = val[lds_pkg::K_W-1:0];
    endtask

    // resting sample near 1 g with small noise, with an occasional spike
    task automatic send_resting();
        logic [15:0] zv;
        zv = 16'd2509 + 16'($urandom_range(0, 200)) - 16'd100;
        if ($urandom_range(0, 19) == 0) zv = 16'($urandom_range(8000, 32767));
        send_sample(16'($urandom_range(0, 120)) - 16'd60,
                    16'($urandom_range(0, 120)) - 16'd60, zv);
    endtask

    task automatic send_full_range();
        send_sample(16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // receiver: random gaps and one long hold
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (hold_req != hold_ack) begin
            m_axis_tready <= 1'b0;
            hold_cycles <= HOLD_LEN;
            hold_ack <= hold_req;
        end else if (rx_gap > 0) begin
            m_axis_tready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end else if (!no_idle && ($urandom_range(0, 99) < 25)) begin
            m_axis_tready <= 1'b0;
            rx_gap <= pick_gap();
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_launch_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_checked++;
            if (m_axis_tuser[0]) n_launch_seen++;
            if (pending_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result: launch_seen=%0d filtered_mean=%0d",
                             m_axis_tuser[0], m_axis_tdata);
            end else begin
                exp_r = pending_results.pop_front();
                if (exp_r.launch_seen !== m_axis_tuser[0]
                    || exp_r.filtered_mean !== m_axis_tdata) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("result %0d mismatch: launch_seen exp %0d got %0d, %s %0d got %0d",
                                 n_checked, exp_r.launch_seen, m_axis_tuser[0],
                                 "filtered_mean exp", exp_r.filtered_mean, m_axis_tdata);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WD_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_directed();
        logic [15:0] corner [4];
        corner[0] = 16'h8000;
        corner[1] = 16'h7FFF;
        corner[2] = 16'h0000;
        corner[3] = 16'hFFFF;
        write_reg(lds_pkg::CFG_THRESHOLD, 16'hFFFF);
        write_reg(lds_pkg::CFG_REJECT, 16'd15);
        for (int i = 0; i < 4; i++) send_sample(corner[i], corner[i], corner[i]);
        send_sample(16'h8000, 16'h7FFF, 16'h0001);
        send_sample(16'h0000, 16'h0000, 16'h09CD);
        send_sample(16'h5555, 16'hAAAA, 16'h5555);
        send_sample(16'hAAAA, 16'h5555, 16'hAAAA);
        for (int i = 0; i < 12; i++) send_resting();
        wait_drained();
    endtask

    task automatic test_resting_stream(int n, logic [lds_pkg::K_W-1:0] k);
        write_reg(lds_pkg::CFG_REJECT, lds_pkg::CFG_DATA_W'(k));
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 9) == 0) send_full_range();
            else send_resting();
        end
        no_idle = 1'b0;
        wait_drained();
    endtask

    task automatic test_full_range(int n);
        write_reg(lds_pkg::CFG_REJECT, lds_pkg::CFG_DATA_W'($urandom_range(1, 15)));
        for (int i = 0; i < n; i++) send_full_range();
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_req++;
        for (int i = 0; i < 10; i++) send_resting();
        wait_drained();
    endtask

    task automatic test_launch();
        int n;
        write_reg(lds_pkg::CFG_REJECT, 16'd3);
        write_reg(lds_pkg::CFG_THRESHOLD, 16'd3000);
        n = 0;
        while (!launched && n < 60) begin
            send_sample(16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
                        16'($urandom_range(4500, 6000)));
            n++;
        end
        if (!launched) begin
            wait_drained();
            write_reg(lds_pkg::CFG_THRESHOLD, 16'd0);
            n = 0;
            while (!launched && n < 60) begin
                send_resting();
                n++;
            end
        end
        for (int i = 0; i < 15; i++) send_full_range();
        wait_drained();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        hold_req      = 0;
        no_idle       = 1'b0;
        n_sent        = 0;
        launched      = 1'b0;
        wr_ptr        = 0;
        thr_reg       = lds_pkg::THR_RST;
        k_reg         = lds_pkg::K_RST;
        for (int i = 0; i < DEPTH; i++) mag_ring[i] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_resting_stream(200, 4'd3);
        test_resting_stream(120, 4'd1);
        test_full_range(60);
        test_resting_stream(10, 4'd0);
        test_backpressure();
        test_resting_stream(80, 4'd15);
        test_launch();

        repeat (50) @(posedge i_clk);
        $display("covered %0d samples over several threshold and reject settings", n_sent);
        $display("checked %0d results, %0d with launch flag, %0d mismatches",
                 n_checked, n_launch_seen, n_mismatch);
        if (n_mismatch == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

[launch_detect_window_stats_unit.f]
+incdir+rtl
rtl/lds_pkg.sv
rtl/lds_ram.sv
rtl/lds_fifo.sv
rtl/lds_front.sv
rtl/lds_back.sv
rtl/launch_detect_window_stats_unit.sv
rtl/launch_detect_window_stats_unit_checker.sv
sim/launch_detect_window_stats_unit_tb.sv
